FILE: rtl/core/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Operation codes, status codes and field widths shared by the deque
// top level and its port checker.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;
    localparam int FILL_W = 4;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_REAR   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_PEEK_FRONT = 3'd4;
    localparam logic [FUNC_W-1:0] FN_PEEK_REAR  = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [DATA_W-1:0] word_t;

endpackage

FILE: rtl/core/circular_deque_top.sv
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue of DEPTH words held in a circular RAM with head, tail
// and occupancy registers.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Pushes and rejected requests give
// their result in the cycle after acceptance; pops and peeks pass through
// the registered read of the slot RAM and then the output register. A new
// request is taken as soon as the previous result has left or leaves in the
// same cycle, so pushes sustain one request per cycle while the receiver
// takes each result; a pop or peek holds off new requests until its data is
// loaded. The slot RAM is not cleared; a read only touches written entries.
module circular_deque_top #(
    parameter int DEPTH = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cdq_pkg::FUNC_W-1:0]   func,
    input  logic signed [cdq_pkg::DATA_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [cdq_pkg::DATA_W-1:0] data_out,
    output logic [cdq_pkg::STAT_W-1:0]   status,
    output logic [cdq_pkg::FILL_W-1:0]   fill_level
);

    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_READ = 1'b1;

    logic [0:0]        state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic              out_valid_reg, out_valid_next;
    word_t             data_reg, data_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [FILL_W-1:0] fill_reg;
    logic              out_load;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    word_t             ram_rdata;

    logic              accept;
    logic              is_front, is_pop, empty, full;
    logic [AW-1:0]     head_inc, head_dec, tail_inc, tail_dec;
    logic [CW+FILL_W-1:0] occ_ext;

    cdq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(value),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign is_front = (func == FN_PUSH_FRONT) || (func == FN_POP_FRONT)
                   || (func == FN_PEEK_FRONT);
    assign is_pop   = (func == FN_POP_FRONT) || (func == FN_POP_REAR);
    assign empty    = (occ_reg == '0);
    assign full     = (occ_reg == CW'(DEPTH));

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
    assign tail_dec = (tail_reg == '0) ? AW'(DEPTH - 1) : tail_reg - AW'(1);

    assign occ_ext  = {{FILL_W{1'b0}}, occ_next};

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_load       = 1'b0;
        data_next      = '0;
        status_next    = ST_DONE;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = '0;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func) inside
                        FN_PUSH_FRONT, FN_PUSH_REAR:
                        begin
                            out_valid_next = 1'b1;
                            out_load       = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                occ_next = occ_reg + CW'(1);
                                if (empty)
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                    ram_waddr = '0;
                                end
                                else if (is_front)
                                begin
                                    head_next = head_dec;
                                    ram_waddr = head_dec;
                                end
                                else
                                begin
                                    tail_next = tail_inc;
                                    ram_waddr = tail_inc;
                                end
                            end
                        end
                        FN_POP_FRONT, FN_POP_REAR, FN_PEEK_FRONT, FN_PEEK_REAR:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                out_load       = 1'b1;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = is_front ? head_reg : tail_reg;
                                state_next = S_READ;
                                if (is_pop)
                                begin
                                    occ_next = occ_reg - CW'(1);
                                    if (occ_reg == CW'(1))
                                    begin
                                        head_next = '0;
                                        tail_next = '0;
                                    end
                                    else if (is_front)
                                    begin
                                        head_next = head_inc;
                                    end
                                    else
                                    begin
                                        tail_next = tail_dec;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_load       = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                out_load       = 1'b1;
                data_next      = ram_rdata;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
            fill_reg   <= occ_ext[FILL_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_out   = data_reg;
    assign status     = status_reg;
    assign fill_level = fill_reg;

endmodule

FILE: rtl/core/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the deque: result holding, rejection results and
// one request in flight.
// ----------------------------------------------------------------------------
module cdq_checker #(
    parameter int DEPTH = 8
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [cdq_pkg::DATA_W-1:0] data_out,
    input logic [cdq_pkg::STAT_W-1:0]   status,
    input logic [cdq_pkg::FILL_W-1:0]   fill_level
);

    import cdq_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_out)
            && $stable(status) && $stable(fill_level))
        else $error("result changed while stalled");

    // no new request while an undelivered result blocks the output
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("request taken with result pending");

    // full rejection reports a full deque and no data
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> data_out == '0
            && fill_level == FILL_W'(DEPTH))
        else $error("bad full rejection");

    // empty rejection reports an empty deque and no data
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> data_out == '0 && fill_level == '0)
        else $error("bad empty rejection");

endmodule

bind circular_deque_top cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (.*);

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular deque. Requests are driven on the
// input channel and mirrored into a behavioral deque that predicts data,
// status and fill level. Every reply is compared against the oldest
// prediction. Directed tests cover empty and full rejections, head
// wrap-around in both directions and the unused selectors. Random traffic
// follows with fill-biased and drain-biased phases, random idling on both
// channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    import cdq_pkg::*;

    localparam int DEPTH       = 8;
    localparam int RAND_ITEMS  = 1950;
    localparam int IDLE_PCT    = 32;
    localparam int HOLD_CYCLES = 80;

    // selectors with no operation behind them
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STAT_W-1:0]        stat;
        logic [FILL_W-1:0]        fill;
    } deque_reply_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] data_out;
    logic [STAT_W-1:0]        status;
    logic [FILL_W-1:0]        fill_level;

    // behavioral copy of the deque
    logic signed [DATA_W-1:0] mirror_slots [DEPTH];
    int                       mirror_head;
    int                       mirror_tail;
    int                       mirror_count;

    deque_reply_t             expected_replies [$];

    int  err_count;
    int  req_count;
    int  reply_count;
    int  full_rejects;
    int  empty_rejects;
    int  peak_fill;
    int  hold_left;
    bit  steady;

    circular_deque_top #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_out   (data_out),
        .status     (status),
        .fill_level (fill_level)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #2000000;
        $display("[circular_deque_top] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // apply one accepted request to the mirror and queue its reply
    task automatic deque_step(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
        deque_reply_t r;
        bit           front;
        r      = '0;
        r.stat = ST_DONE;
        case (f) inside
            FN_PUSH_FRONT, FN_PUSH_REAR:
            begin
                if (mirror_count >= DEPTH)
                begin
                    r.stat = ST_FULL;
                    full_rejects++;
                end
                else
                begin
                    if (mirror_count == 0)
                    begin
                        mirror_head     = 0;
                        mirror_tail     = 0;
                        mirror_slots[0] = v;
                    end
                    else if (f == FN_PUSH_FRONT)
                    begin
                        mirror_head = (mirror_head == 0) ? DEPTH - 1 : mirror_head - 1;
                        mirror_slots[mirror_head] = v;
                    end
                    else
                    begin
                        mirror_tail = (mirror_tail + 1 >= DEPTH) ? 0 : mirror_tail + 1;
                        mirror_slots[mirror_tail] = v;
                    end
                    mirror_count++;
                end
            end
            FN_POP_FRONT, FN_POP_REAR, FN_PEEK_FRONT, FN_PEEK_REAR:
            begin
                if (mirror_count == 0)
                begin
                    r.stat = ST_EMPTY;
                    empty_rejects++;
                end
                else
                begin
                    front  = (f == FN_POP_FRONT) || (f == FN_PEEK_FRONT);
                    r.data = front ? mirror_slots[mirror_head] : mirror_slots[mirror_tail];
                    if ((f == FN_POP_FRONT) || (f == FN_POP_REAR))
                    begin
                        if (mirror_count == 1)
                        begin
                            mirror_head = 0;
                            mirror_tail = 0;
                        end
                        else if (front)
                            mirror_head = (mirror_head + 1 >= DEPTH) ? 0 : mirror_head + 1;
                        else
                            mirror_tail = (mirror_tail == 0) ? DEPTH - 1 : mirror_tail - 1;
                        mirror_count--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.fill = mirror_count[FILL_W-1:0];
        if (mirror_count > peak_fill)
            peak_fill = mirror_count;
        req_count++;
        expected_replies.push_back(r);
    endtask

    // entered and left at a falling edge; valid stays high on return
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
        int gap;
        if (!steady && ($urandom_range(99) < IDLE_PCT))
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        deque_step(f, v);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(negedge clk);
    endtask

    // receiver side: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        deque_reply_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            reply_count++;
            if (expected_replies.size() == 0)
                report_mismatch($sformatf("unexpected reply data %0d status %0d fill %0d",
                                          data_out, status, fill_level));
            else
            begin
                exp_r = expected_replies.pop_front();
                if (data_out !== exp_r.data)
                    report_mismatch($sformatf("data_out %0d, expected %0d",
                                              data_out, exp_r.data));
                if (status !== exp_r.stat)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, exp_r.stat));
                if (fill_level !== exp_r.fill)
                    report_mismatch($sformatf("fill_level %0d, expected %0d",
                                              fill_level, exp_r.fill));
            end
        end
    end

    task automatic test_empty_rejects();
        send_request(FN_POP_FRONT, 32'sd5);
        send_request(FN_POP_REAR, -32'sd1);
        send_request(FN_PEEK_FRONT, 32'sd0);
        send_request(FN_PEEK_REAR, 32'sh7fffffff);
        send_request(FN_SPARE_LO, 32'sh12345678);
        send_request(FN_SPARE_HI, 32'sh80000000);
    endtask

    // fill from both ends so the head wraps below zero, then drain
    task automatic test_full_and_wrap();
        send_request(FN_PUSH_FRONT, 32'sh7fffffff);
        send_request(FN_PUSH_FRONT, 32'sh80000000);
        send_request(FN_PUSH_REAR, -32'sd1);
        send_request(FN_PUSH_FRONT, 32'sd0);
        send_request(FN_PUSH_REAR, 32'sh5a5a5a5a);
        send_request(FN_PUSH_FRONT, 32'sha5a5a5a5);
        send_request(FN_PUSH_REAR, 32'sd1);
        send_request(FN_PUSH_FRONT, -32'sd2);
        send_request(FN_PUSH_FRONT, 32'sd99);
        send_request(FN_PUSH_REAR, 32'sd98);
        send_request(FN_PEEK_FRONT, 32'sd0);
        send_request(FN_PEEK_REAR, 32'sd0);
        send_request(FN_POP_FRONT, 32'sd0);
        send_request(FN_POP_REAR, 32'sd0);
        send_request(FN_POP_FRONT, 32'sd0);
        send_request(FN_POP_REAR, 32'sd0);
        send_request(FN_POP_FRONT, 32'sd0);
        send_request(FN_POP_REAR, 32'sd0);
        send_request(FN_POP_FRONT, 32'sd0);
        send_request(FN_POP_REAR, 32'sd0);
        wait_drained();
    endtask

    // long receiver stall while requests keep coming
    task automatic test_backpressure();
        int i;
        hold_left = HOLD_CYCLES;
        for (i = 0; i < 12; i++)
        begin
            if (i % 3 == 2)
                send_request(FN_PEEK_REAR, 32'sd0);
            else
                send_request((i % 2) ? FN_PUSH_REAR : FN_PUSH_FRONT, $urandom);
        end
        wait_drained();
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_traffic();
        int                i;
        int                push_pct;
        int                roll;
        logic [FUNC_W-1:0] f;
        push_pct = 50;
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 40 == 0)
                push_pct = $urandom_range(2) == 0 ? 75 : ($urandom_range(1) ? 25 : 50);
            steady = (i >= 900) && (i < 1200);
            if (i == 1500)
                hold_left = HOLD_CYCLES;
            if (i == 1700)
                wait_drained();
            roll = $urandom_range(99);
            if (roll < 3)
                f = $urandom_range(1) ? FN_SPARE_HI : FN_SPARE_LO;
            else if (roll < 3 + push_pct)
                f = $urandom_range(1) ? FN_PUSH_REAR : FN_PUSH_FRONT;
            else
            begin
                case ($urandom_range(3))
                    0:       f = FN_POP_FRONT;
                    1:       f = FN_POP_REAR;
                    2:       f = FN_PEEK_FRONT;
                    default: f = FN_PEEK_REAR;
                endcase
            end
            send_request(f, pick_word());
        end
        steady = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = '0;
        value        = '0;
        out_ready    = 1'b0;
        err_count    = 0;
        req_count    = 0;
        reply_count  = 0;
        full_rejects = 0;
        empty_rejects = 0;
        peak_fill    = 0;
        hold_left    = 0;
        steady       = 1'b0;
        mirror_head  = 0;
        mirror_tail  = 0;
        mirror_count = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_rejects();
        test_full_and_wrap();
        test_backpressure();
        test_random_traffic();

        repeat (10) @(negedge clk);
        if (expected_replies.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));

        $display("covered %0d requests, %0d replies, peak fill %0d of %0d",
                 req_count, reply_count, peak_fill, DEPTH);
        $display("rejections seen: %0d on full, %0d on empty; errors %0d",
                 full_rejects, empty_rejects, err_count);
        if (err_count == 0)
            $display("[circular_deque_top] OK");
        else
            $display("[circular_deque_top] ERROR");
        $finish;
    end

endmodule
